/* rtl/hjc_pkg.sv */
// shared types, constants and the compatibility jamo table
`timescale 1ns / 1ps
`default_nettype none
package hjc_pkg;

   localparam int CharWidth  = 16;
   localparam int CountWidth = 16;
   localparam int FifoDepth  = 4;

   localparam logic [CharWidth-1:0] LEAD_FIRST  = 16'h1100;
   localparam logic [CharWidth-1:0] LEAD_END    = 16'h1112;
   localparam logic [CharWidth-1:0] VOWEL_FIRST = 16'h1161;
   localparam logic [CharWidth-1:0] VOWEL_END   = 16'h1175;
   localparam logic [CharWidth-1:0] TRAIL_BASE  = 16'h11A7;
   localparam logic [CharWidth-1:0] TRAIL_END   = 16'h11C2;
   localparam logic [CharWidth-1:0] JAMO_END    = 16'h11FF;
   localparam logic [CharWidth-1:0] SYL_BASE    = 16'hAC00;
   localparam logic [CharWidth-1:0] COMPAT_PAGE = 16'h3100;
   localparam logic [CountWidth-1:0] MAX_OUT_RESET = 16'hFFFF;

   typedef enum logic [1:0] {
      HOLD_NONE = 2'd0,
      HOLD_LEAD = 2'd1,
      HOLD_PAIR = 2'd2
   } hold_type;

   typedef struct packed {
      logic [CharWidth-1:0]  ch;
      logic                  last;
      logic                  ovf;
      logic [CountWidth-1:0] count;
   } res_type;

   localparam logic [7:0] COMPAT_MAP [256] = '{
      8'h31,8'h32,8'h34,8'h37,8'h38,8'h39,8'h41,8'h42,8'h43,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4A,8'h4B,
      8'h4C,8'h4D,8'h4E,8'h64,8'h65,8'h66,8'h64,8'h64,8'h64,8'h64,8'h40,8'h64,8'h6E,8'h71,8'h72,8'h64,
      8'h73,8'h44,8'h74,8'h75,8'h64,8'h64,8'h64,8'h76,8'h64,8'h77,8'h64,8'h78,8'h79,8'h7A,8'h7B,8'h7C,
      8'h64,8'h64,8'h7D,8'h64,8'h64,8'h64,8'h7E,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,
      8'h7F,8'h64,8'h64,8'h64,8'h64,8'h82,8'h83,8'h84,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,
      8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h84,8'h85,8'h86,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,
      8'h64,8'h4F,8'h50,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,8'h5A,8'h5B,8'h5C,8'h5D,
      8'h5E,8'h5F,8'h60,8'h61,8'h62,8'h63,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,
      8'h64,8'h64,8'h64,8'h64,8'h87,8'h88,8'h64,8'h64,8'h89,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,
      8'h64,8'h8A,8'h8B,8'h64,8'h8C,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h8D,8'h64,
      8'h64,8'h8E,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h39,
      8'h3A,8'h3B,8'h3C,8'h3D,8'h3E,8'h3F,8'h40,8'h41,8'h42,8'h44,8'h45,8'h46,8'h47,8'h48,8'h4A,8'h4B,
      8'h4C,8'h4D,8'h4E,8'h64,8'h64,8'h64,8'h66,8'h67,8'h68,8'h64,8'h64,8'h64,8'h69,8'h64,8'h6A,8'h64,
      8'h64,8'h64,8'h64,8'h6B,8'h64,8'h64,8'h64,8'h6C,8'h64,8'h6D,8'h64,8'h64,8'h6E,8'h6F,8'h64,8'h70,
      8'h64,8'h64,8'h71,8'h64,8'h64,8'h64,8'h78,8'h7A,8'h7C,8'h64,8'h7D,8'h7F,8'h64,8'h64,8'h80,8'h64,
      8'h81,8'h82,8'h83,8'h64,8'h84,8'h64,8'h64,8'h64,8'h64,8'h86,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64
   };

   function automatic logic [CharWidth-1:0] compat(input logic [7:0] idx);
      return COMPAT_PAGE + {8'd0, COMPAT_MAP[idx]};
   endfunction

endpackage
`default_nettype wire

/* rtl/hjc_out_fifo.sv */
// four-entry result queue taking up to two results per cycle
`timescale 1ns / 1ps
`default_nettype none
module hjc_out_fifo
   import hjc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic [1:0] push_n,
   input  wire res_type push0,
   input  wire res_type push1,
   output logic         room2,
   output logic         out_valid,
   output res_type      out_res,
   input  wire logic    out_ready
);
   res_type mem_ff [FifoDepth];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;
   logic pop;

   assign out_valid = (cnt_ff != 3'd0);
   assign out_res   = mem_ff[rd_ff];
   assign pop       = out_valid && out_ready;
   assign room2     = (cnt_ff <= 3'd2);

   always_comb begin
      wr_in  = wr_ff + push_n;
      rd_in  = rd_ff + {1'b0, pop};
      cnt_in = cnt_ff + {1'b0, push_n} - {2'd0, pop};
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) mem_ff[wr_ff] <= push0;
      if (push_n == 2'd2) mem_ff[wr_ff + 2'd1] <= push1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

/* rtl/hjc_core.sv */
// input register, held-jamo state and composition logic
`timescale 1ns / 1ps
`default_nettype none
module hjc_core
   import hjc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [CharWidth-1:0]  in_char,
   input  wire logic                  in_last,
   input  wire logic                  csr_valid,
   input  wire logic [CountWidth-1:0] csr_data,
   input  wire logic                  room2,
   output logic [1:0]                 push_n,
   output res_type                    push0,
   output res_type                    push1
);
   logic                  valid_ff;
   logic [CharWidth-1:0]  char_ff;
   logic                  last_ff;
   logic [CountWidth-1:0] max_ff;
   hold_type              hold_ff, hold_in;
   logic [4:0]            lead_ff, lead_in, vowel_ff, vowel_in;
   logic [CountWidth-1:0] cnt_ff, cnt_in;
   logic                  ovfd_ff, ovfd_in;
   logic                  fire;
   logic [CharWidth-1:0]  syl_base;

   assign fire     = valid_ff && room2;
   assign in_ready = !valid_ff || fire;

   // (L*21 + V)*28 offset from the held pair, narrow constant multiplies
   assign syl_base = SYL_BASE + ((CharWidth'(lead_ff) * 16'd21 + CharWidth'(vowel_ff)) * 16'd28);

   always_comb begin
      res_type r [2];
      logic [1:0] n;
      logic sg, ovf_now;
      logic [CharWidth-1:0] c;
      c        = char_ff;
      n        = 2'd0;
      sg       = 1'b0;
      ovf_now  = 1'b0;
      r[0]     = '0;
      r[1]     = '0;
      hold_in  = hold_ff;
      lead_in  = lead_ff;
      vowel_in = vowel_ff;
      cnt_in   = cnt_ff;
      ovfd_in  = ovfd_ff;
      if (ovfd_ff) begin
         if (last_ff) begin
            ovfd_in = 1'b0;
            cnt_in  = '0;
            hold_in = HOLD_NONE;
         end
      end else begin
         case (hold_ff)
            HOLD_LEAD: begin
               if (c >= VOWEL_FIRST && c <= VOWEL_END) begin
                  vowel_in = c[4:0] - VOWEL_FIRST[4:0];
                  hold_in  = HOLD_PAIR;
               end else begin
                  r[0].ch = compat({3'd0, lead_ff});
                  n = 2'd1; cnt_in = cnt_in + 16'd1;
                  hold_in = HOLD_NONE;
                  sg = 1'b1;
               end
            end
            HOLD_PAIR: begin
               hold_in = HOLD_NONE;
               n = 2'd1; cnt_in = cnt_in + 16'd1;
               if (c > TRAIL_BASE && c <= TRAIL_END) begin
                  r[0].ch = syl_base + (c - TRAIL_BASE);
               end else begin
                  r[0].ch = syl_base;
                  sg = 1'b1;
               end
            end
            default: begin
               hold_in = HOLD_NONE;
               sg = 1'b1;
            end
         endcase
         if (sg) begin
            if (cnt_in >= max_ff) begin
               r[n[0]].ch   = '0;
               r[n[0]].last = 1'b1;
               r[n[0]].ovf  = 1'b1;
               n = n + 2'd1;
               ovf_now = 1'b1;
               hold_in = HOLD_NONE;
            end else if (c >= LEAD_FIRST && c <= LEAD_END) begin
               lead_in = c[4:0];
               hold_in = HOLD_LEAD;
            end else begin
               r[n[0]].ch = (c >= LEAD_FIRST && c <= JAMO_END) ? compat(c[7:0]) : c;
               n = n + 2'd1; cnt_in = cnt_in + 16'd1;
            end
         end
         if (!ovf_now && last_ff) begin
            // flush what is still held
            if (hold_in == HOLD_LEAD) begin
               r[n[0]].ch = compat({3'd0, lead_in});
               n = n + 2'd1; cnt_in = cnt_in + 16'd1;
            end else if (hold_in == HOLD_PAIR) begin
               r[n[0]].ch = SYL_BASE + ((CharWidth'(lead_in) * 16'd21
                            + CharWidth'(vowel_in)) * 16'd28);
               n = n + 2'd1; cnt_in = cnt_in + 16'd1;
            end
            if (n == 2'd2) begin
               r[1].last = 1'b1; r[1].count = cnt_in;
            end else if (n == 2'd1) begin
               r[0].last = 1'b1; r[0].count = cnt_in;
            end
         end
         if (last_ff) begin
            hold_in = HOLD_NONE;
            cnt_in  = '0;
            ovfd_in = 1'b0;
         end else if (ovf_now) begin
            ovfd_in = 1'b1;
         end
      end
      push_n = fire ? n : 2'd0;
      push0  = r[0];
      push1  = r[1];
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         char_ff <= in_char;
         last_ff <= in_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         max_ff   <= MAX_OUT_RESET;
         hold_ff  <= HOLD_NONE;
         lead_ff  <= '0;
         vowel_ff <= '0;
         cnt_ff   <= '0;
         ovfd_ff  <= 1'b0;
      end else begin
         if (in_ready) valid_ff <= in_valid;
         if (csr_valid) max_ff <= csr_data;
         if (fire) begin
            hold_ff  <= hold_in;
            lead_ff  <= lead_in;
            vowel_ff <= vowel_in;
            cnt_ff   <= cnt_in;
            ovfd_ff  <= ovfd_in;
         end
      end
   end
endmodule
`default_nettype wire

/* rtl/hangul_jamo_compose.sv */
// top level of the hangul jamo composer
`timescale 1ns / 1ps
`default_nettype none
// Composes decomposed UTF-16 hangul jamo into syllables, one code unit per cycle
// while the output buffer has room for two results: a beat is registered, composed
// combinationally against the held lead/vowel state, and its zero to two results are
// queued in a four-entry output buffer; a beat that yields two results is absorbed by
// the buffer, which takes both at once. max_out is written on the csr channel,
// always ready, and should only be changed between strings.
module hangul_jamo_compose
   import hjc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // in_char
   input  wire logic        req_tlast,   // in_last
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // out_char, out_count
   output logic             rsp_tlast,   // out_last
   output logic             rsp_tuser,   // overflow
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data    // max_out
);
   logic    room2;
   logic [1:0] push_n;
   res_type push0, push1, head;

   assign csr_ready = 1'b1;

   hjc_core u_core (
      .clock, .reset,
      .in_valid (req_tvalid), .in_ready (req_tready),
      .in_char  (req_tdata),  .in_last  (req_tlast),
      .csr_valid, .csr_data,
      .room2, .push_n, .push0, .push1
   );

   hjc_out_fifo u_fifo (
      .clock, .reset,
      .push_n, .push0, .push1, .room2,
      .out_valid (rsp_tvalid), .out_res (head), .out_ready (rsp_tready)
   );

   assign rsp_tdata = {head.count, head.ch};
   assign rsp_tlast = head.last;
   assign rsp_tuser = head.ovf;
endmodule
`default_nettype wire

/* verif/tb_hangul_jamo_compose.sv */
// self-checking testbench for the hangul jamo composer with a built-in composition predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_hangul_jamo_compose
   import hjc_pkg::*;
();

   typedef struct {
      logic [15:0] ch;
      logic        last;
   } unit_in_type;

   typedef struct {
      logic [15:0] ch;
      logic        last;
      logic        ovf;
      logic [15:0] cnt;
   } unit_out_type;

   localparam logic [7:0] JAMO_TO_COMPAT [256] = '{
      8'h31,8'h32,8'h34,8'h37,8'h38,8'h39,8'h41,8'h42,8'h43,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4A,8'h4B,
      8'h4C,8'h4D,8'h4E,8'h64,8'h65,8'h66,8'h64,8'h64,8'h64,8'h64,8'h40,8'h64,8'h6E,8'h71,8'h72,8'h64,
      8'h73,8'h44,8'h74,8'h75,8'h64,8'h64,8'h64,8'h76,8'h64,8'h77,8'h64,8'h78,8'h79,8'h7A,8'h7B,8'h7C,
      8'h64,8'h64,8'h7D,8'h64,8'h64,8'h64,8'h7E,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,
      8'h7F,8'h64,8'h64,8'h64,8'h64,8'h82,8'h83,8'h84,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,
      8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h84,8'h85,8'h86,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,
      8'h64,8'h4F,8'h50,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,8'h5A,8'h5B,8'h5C,8'h5D,
      8'h5E,8'h5F,8'h60,8'h61,8'h62,8'h63,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,
      8'h64,8'h64,8'h64,8'h64,8'h87,8'h88,8'h64,8'h64,8'h89,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,
      8'h64,8'h8A,8'h8B,8'h64,8'h8C,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h8D,8'h64,
      8'h64,8'h8E,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h39,
      8'h3A,8'h3B,8'h3C,8'h3D,8'h3E,8'h3F,8'h40,8'h41,8'h42,8'h44,8'h45,8'h46,8'h47,8'h48,8'h4A,8'h4B,
      8'h4C,8'h4D,8'h4E,8'h64,8'h64,8'h64,8'h66,8'h67,8'h68,8'h64,8'h64,8'h64,8'h69,8'h64,8'h6A,8'h64,
      8'h64,8'h64,8'h64,8'h6B,8'h64,8'h64,8'h64,8'h6C,8'h64,8'h6D,8'h64,8'h64,8'h6E,8'h6F,8'h64,8'h70,
      8'h64,8'h64,8'h71,8'h64,8'h64,8'h64,8'h78,8'h7A,8'h7C,8'h64,8'h7D,8'h7F,8'h64,8'h64,8'h80,8'h64,
      8'h81,8'h82,8'h83,8'h64,8'h84,8'h64,8'h64,8'h64,8'h64,8'h86,8'h64,8'h64,8'h64,8'h64,8'h64,8'h64
   };

   localparam int CYCLE_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   unit_in_type  pending_units[$];
   unit_out_type expected_units[$];
   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;
   int        fail_count = 0;
   int        cycle_count = 0;

   // composer state mirror
   logic [15:0] limit_units = MAX_OUT_RESET;
   hold_type    hold = HOLD_NONE;
   logic [4:0]  lead_idx = '0;
   logic [4:0]  vowel_idx = '0;
   logic [15:0] units_done = '0;
   logic        dropping = 1'b0;
   logic        ovf_now;

   hangul_jamo_compose dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic logic [15:0] compat_of(input logic [15:0] c);
      return COMPAT_PAGE + {8'd0, JAMO_TO_COMPAT[c[7:0]]};
   endfunction

   function automatic logic [15:0] syllable_of(input logic [15:0] t);
      return SYL_BASE + (16'(lead_idx) * 16'd21 + 16'(vowel_idx)) * 16'd28 + t;
   endfunction

   function automatic void push_unit(input logic [15:0] c);
      unit_out_type u;
      u = '{c, 1'b0, 1'b0, 16'd0};
      expected_units.push_back(u);
      units_done = units_done + 16'd1;
   endfunction

   function automatic void open_group(input logic [15:0] c);
      unit_out_type u;
      if (units_done >= limit_units) begin
         u = '{16'd0, 1'b1, 1'b1, 16'd0};
         expected_units.push_back(u);
         ovf_now = 1'b1;
         hold = HOLD_NONE;
      end else if (c >= LEAD_FIRST && c <= LEAD_END) begin
         lead_idx = 5'(c - LEAD_FIRST);
         hold = HOLD_LEAD;
      end else if (c >= LEAD_FIRST && c <= JAMO_END) begin
         push_unit(compat_of(c));
      end else begin
         push_unit(c);
      end
   endfunction

   function automatic void compose_beat(input logic [15:0] c, input logic last);
      int           prior_n;
      unit_out_type u;
      prior_n = expected_units.size();
      ovf_now = 1'b0;
      if (dropping) begin
         if (last) begin
            dropping = 1'b0;
            units_done = '0;
            hold = HOLD_NONE;
         end
         return;
      end
      case (hold)
         HOLD_LEAD: begin
            if (c >= VOWEL_FIRST && c <= VOWEL_END) begin
               vowel_idx = 5'(c - VOWEL_FIRST);
               hold = HOLD_PAIR;
            end else begin
               push_unit(compat_of({11'd0, lead_idx}));
               hold = HOLD_NONE;
               open_group(c);
            end
         end
         HOLD_PAIR: begin
            hold = HOLD_NONE;
            if (c > TRAIL_BASE && c <= TRAIL_END) begin
               push_unit(syllable_of(c - TRAIL_BASE));
            end else begin
               push_unit(syllable_of(16'd0));
               open_group(c);
            end
         end
         default: open_group(c);
      endcase
      if (!ovf_now && last) begin
         if (hold == HOLD_LEAD) push_unit(compat_of({11'd0, lead_idx}));
         else if (hold == HOLD_PAIR) push_unit(syllable_of(16'd0));
         if (expected_units.size() > prior_n) begin
            u = expected_units.pop_back();
            u.last = 1'b1;
            u.cnt = units_done;
            expected_units.push_back(u);
         end
      end
      if (last) begin
         hold = HOLD_NONE;
         units_done = '0;
         dropping = 1'b0;
      end else if (ovf_now) begin
         dropping = 1'b1;
      end
   endfunction

   task automatic report_mismatch(input string field, input logic [15:0] want,
                                  input logic [15:0] got);
      $display("mismatch on %s: expected %h, got %h at %0t", field, want, got, $realtime);
      fail_count++;
   endtask

   // driver
   always @(posedge clock) begin : drive_req
      unit_in_type u;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         if (!req_tvalid || req_tready) begin
            if (pending_units.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               u = pending_units.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= u.ch;
               req_tlast <= u.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: predict on accepted input beats, check accepted result beats
   always @(posedge clock) begin : watch
      unit_out_type w;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else if (!reset) begin
         if (csr_valid && csr_ready) limit_units = csr_data;
         if (req_tvalid && req_tready) compose_beat(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_units.size() == 0) begin
               report_mismatch("unexpected beat", 16'd0, rsp_tdata[15:0]);
            end else begin
               w = expected_units.pop_front();
               if (rsp_tdata[15:0] !== w.ch) report_mismatch("out_char", w.ch, rsp_tdata[15:0]);
               if (rsp_tlast !== w.last) report_mismatch("out_last", w.last, rsp_tlast);
               if (rsp_tuser !== w.ovf) report_mismatch("overflow", w.ovf, rsp_tuser);
               if (rsp_tdata[31:16] !== w.cnt)
                  report_mismatch("out_count", w.cnt, rsp_tdata[31:16]);
            end
         end
      end
   end

   task automatic add_beat(input logic [15:0] c, input logic last);
      unit_in_type u;
      u = '{c, last};
      pending_units.push_back(u);
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_units.size() > 0 || req_tvalid || expected_units.size() > 0);
      // a beat with no result may still be in flight
      repeat (10) @(posedge clock);
   endtask

   task automatic write_limit(input logic [15:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic random_strings(input int n_beats);
      int          n;
      int          len;
      int          kind;
      logic [15:0] c;
      n = 0;
      while (n < n_beats) begin
         len = $urandom_range(1, 8);
         for (int k = 0; k < len; k++) begin
            kind = $urandom_range(99);
            if (kind < 60) begin
               // well-formed syllable, sometimes with a trailing consonant
               add_beat(LEAD_FIRST + 16'($urandom_range(18)), 1'b0);
               add_beat(VOWEL_FIRST + 16'($urandom_range(20)), 1'b0);
               if ($urandom_range(1)) add_beat(TRAIL_BASE + 16'($urandom_range(1, 27)), 1'b0);
               n += 3;
            end else begin
               if (kind < 80) c = LEAD_FIRST + 16'($urandom_range(255));
               else if (kind < 83) c = 16'd0;
               else c = 16'($urandom_range(16'hFFFF));
               add_beat(c, 1'b0);
               n++;
            end
         end
         add_beat(16'($urandom_range(16'hFFFF)), 1'b1);
         n++;
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: limit of two per string
      write_limit(16'd2);
      add_beat(16'h1100, 1'b0); add_beat(16'h1161, 1'b0); add_beat(16'h11A8, 1'b1);
      add_beat(16'h1112, 1'b0); add_beat(16'h1175, 1'b1);
      add_beat(16'h1105, 1'b1);
      add_beat(16'h1175, 1'b1);
      add_beat(16'h0000, 1'b0); add_beat(16'hFFFF, 1'b1);
      add_beat(16'h11FF, 1'b0); add_beat(16'h11C2, 1'b1);
      add_beat(16'h1100, 1'b0); add_beat(16'h1112, 1'b0);
      add_beat(16'h1161, 1'b0); add_beat(16'h11C3, 1'b1);
      // overflow mid-string, then dropped beats up to the end mark
      add_beat(16'h0041, 1'b0); add_beat(16'h0042, 1'b0);
      add_beat(16'h0043, 1'b0); add_beat(16'h1100, 1'b0); add_beat(16'h0044, 1'b1);
      add_beat(16'h0045, 1'b0); add_beat(16'h0046, 1'b0); add_beat(16'h0047, 1'b1);
      wait_idle();

      send_idle_pct = 15; recv_idle_pct = 63;
      write_limit(16'd5);
      random_strings(300);
      wait_idle();

      send_idle_pct = 63; recv_idle_pct = 15;
      write_limit(16'hFFFF);
      random_strings(300);
      wait_idle();

      send_idle_pct = 0; recv_idle_pct = 0;
      write_limit(16'd3);
      random_strings(300);
      wait_idle();

      write_limit(16'd0);
      random_strings(50);
      wait_idle();

      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule
`default_nettype wire
